>>> design/pfba_pkg.sv
package pfba_pkg;

   // Frame and field geometry
   localparam int NUM_FRAMES       = 65536;
   localparam int FIELD_MAX_FRAMES = 65536;
   localparam int MAX_LIMIT        = (NUM_FRAMES < FIELD_MAX_FRAMES) ? NUM_FRAMES
                                                                     : FIELD_MAX_FRAMES;
   localparam int FRAME_W   = 16;
   localparam int CNT_W     = 17;
   localparam int WORD_BITS = 32;
   localparam int OFF_W     = 5;
   localparam int WIDX_W    = FRAME_W - OFF_W;
   localparam int MEM_WORDS = (MAX_LIMIT + WORD_BITS - 1) / WORD_BITS;
   localparam int MEM_AW    = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
   localparam int POP_W     = OFF_W + 1;

   localparam logic [CNT_W-1:0] CNT_MAX     = '1;
   localparam logic [CNT_W-1:0] LIMIT_RESET = CNT_W'(65536);

   // Register file
   localparam int   CSR_AW             = 3;
   localparam logic REG_FRAME_LIMIT_IDX = 1'b0;

   typedef enum logic [2:0] {
      OP_REQUEST   = 3'd0,
      OP_FREE      = 3'd1,
      OP_LOCK      = 3'd2,
      OP_RESERVE   = 3'd3,
      OP_UNRESERVE = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      ST_DONE   = 2'd0,
      ST_NO_MEM = 2'd1,
      ST_BEYOND = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_SPAN,
      S_READ,
      S_EVAL,
      S_ACC,
      S_DONE
   } state_type;

   typedef struct packed {
      logic ready;
      logic load;
      logic span;
      logic rd;
      logic eval;
      logic acc;
      logic emit;
      logic clr;
   } ctrl_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic skip;
      logic finish;
   } dp_stat_type;

   // Population count as a tree of independent adds
   function automatic logic [POP_W-1:0] pop32(input logic [WORD_BITS-1:0] v);
      logic [1:0] l1 [16];
      logic [2:0] l2 [8];
      logic [3:0] l3 [4];
      logic [4:0] l4 [2];
      for (int i = 0; i < 16; i++) l1[i] = {1'b0, v[2*i]} + {1'b0, v[2*i+1]};
      for (int i = 0; i < 8; i++)  l2[i] = {1'b0, l1[2*i]} + {1'b0, l1[2*i+1]};
      for (int i = 0; i < 4; i++)  l3[i] = {1'b0, l2[2*i]} + {1'b0, l2[2*i+1]};
      for (int i = 0; i < 2; i++)  l4[i] = {1'b0, l3[2*i]} + {1'b0, l3[2*i+1]};
      return {1'b0, l4[0]} + {1'b0, l4[1]};
   endfunction

   // Position of the lowest set bit: isolate it, then encode the one-hot word
   function automatic logic [OFF_W-1:0] low_pos(input logic [WORD_BITS-1:0] v);
      logic [WORD_BITS-1:0] iso;
      logic [OFF_W-1:0]     p;
      iso = v & (~v + WORD_BITS'(1));
      p   = '0;
      for (int i = 0; i < WORD_BITS; i++) begin
         if (iso[i]) p = p | OFF_W'(i);
      end
      return p;
   endfunction

endpackage

>>> design/pfba_ctrl.sv
module pfba_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    out_free,
   input  pfba_pkg::dp_stat_type   stat,
   output pfba_pkg::ctrl_cmd_type  cmd,
   output pfba_pkg::state_type     state
);

   pfba_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= pfba_pkg::S_CLEAR;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pfba_pkg::S_CLEAR: if (stat.clear_last) state_in = pfba_pkg::S_IDLE;
         pfba_pkg::S_IDLE:  if (req_valid) state_in = pfba_pkg::S_SPAN;
         pfba_pkg::S_SPAN:  state_in = pfba_pkg::S_READ;
         pfba_pkg::S_READ:  state_in = stat.skip ? pfba_pkg::S_DONE : pfba_pkg::S_EVAL;
         pfba_pkg::S_EVAL:  state_in = pfba_pkg::S_ACC;
         pfba_pkg::S_ACC:   state_in = stat.finish ? pfba_pkg::S_DONE : pfba_pkg::S_READ;
         pfba_pkg::S_DONE:  if (out_free) state_in = pfba_pkg::S_IDLE;
         default:           state_in = pfba_pkg::S_CLEAR;
      endcase
   end

   always_comb begin
      cmd = '0;
      case (state_ff)
         pfba_pkg::S_CLEAR: cmd.clr = 1'b1;
         pfba_pkg::S_IDLE: begin
            cmd.ready = 1'b1;
            cmd.load  = req_valid;
         end
         pfba_pkg::S_SPAN:  cmd.span = 1'b1;
         pfba_pkg::S_READ:  cmd.rd   = 1'b1;
         pfba_pkg::S_EVAL:  cmd.eval = 1'b1;
         pfba_pkg::S_ACC:   cmd.acc  = 1'b1;
         pfba_pkg::S_DONE:  cmd.emit = out_free;
         default:           cmd = '0;
      endcase
   end

   assign state = state_ff;

endmodule

>>> design/pfba_dpath.sv
module pfba_dpath (
   input  logic                                clock,
   input  logic                                reset,
   input  pfba_pkg::ctrl_cmd_type              cmd,
   input  logic [2:0]                          in_opcode,
   input  logic [pfba_pkg::FRAME_W-1:0]        in_frame_number,
   input  logic [pfba_pkg::CNT_W-1:0]          in_frame_count,
   input  logic [pfba_pkg::CNT_W-1:0]          frame_limit,
   output pfba_pkg::dp_stat_type               stat,
   output logic [pfba_pkg::FRAME_W-1:0]        granted_frame,
   output logic [1:0]                          status,
   output logic [pfba_pkg::CNT_W-1:0]          free_frames,
   output logic [pfba_pkg::CNT_W-1:0]          used_frames,
   output logic [pfba_pkg::CNT_W-1:0]          reserved_frames
);

   localparam int FW = pfba_pkg::FRAME_W;
   localparam int CW = pfba_pkg::CNT_W;
   localparam int WB = pfba_pkg::WORD_BITS;
   localparam int OW = pfba_pkg::OFF_W;
   localparam int IW = pfba_pkg::WIDX_W;
   localparam int AW = pfba_pkg::MEM_AW;
   localparam int PW = pfba_pkg::POP_W;

   function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] c, input logic [PW-1:0] n);
      logic [CW:0] s;
      s = {1'b0, c} + (CW+1)'(n);
      return s[CW] ? pfba_pkg::CNT_MAX : s[CW-1:0];
   endfunction

   function automatic logic [CW-1:0] sat_sub(input logic [CW-1:0] c, input logic [PW-1:0] n);
      return (c >= CW'(n)) ? c - CW'(n) : '0;
   endfunction

   logic [WB-1:0] mem [pfba_pkg::MEM_WORDS];

   logic [2:0]    op_ff;
   logic [FW-1:0] first_ff;
   logic [CW-1:0] count_ff;
   logic [FW-1:0] lo_ff, hi_ff;
   logic          skip_ff;
   logic [1:0]    status_ff;
   logic [IW-1:0] word_ff;
   logic [WB-1:0] rd_ff;
   logic          chg_any_ff;
   logic [OW-1:0] pos_ff;
   logic [PW-1:0] pop_ff;
   logic [CW-1:0] ss_ff, used_ff, rsv_ff;
   logic [FW-1:0] granted_ff;
   logic [AW-1:0] clr_ff;

   logic [CW-1:0] lim;
   logic          is_req, is_clr_op, is_set_range, set_like;
   logic [CW:0]   end_sum, end_ex, lim_x;
   logic          span_skip;
   logic [FW-1:0] span_lo, span_hi;
   logic [1:0]    span_status;
   logic [WB-1:0] lo_mask, hi_mask, mask, chg, new_word, wdata;
   logic [OW-1:0] pos;
   logic [PW-1:0] pop;
   logic          last;
   logic [FW-1:0] cur_idx;
   logic          we;
   logic [AW-1:0] waddr;
   logic [CW:0]   total;

   assign lim   = (frame_limit > CW'(pfba_pkg::MAX_LIMIT)) ? CW'(pfba_pkg::MAX_LIMIT)
                                                           : frame_limit;
   assign lim_x = {1'b0, lim};

   assign is_req       = (op_ff == pfba_pkg::OP_REQUEST);
   assign is_clr_op    = (op_ff == pfba_pkg::OP_FREE) || (op_ff == pfba_pkg::OP_UNRESERVE);
   assign is_set_range = (op_ff == pfba_pkg::OP_LOCK) || (op_ff == pfba_pkg::OP_RESERVE);
   assign set_like     = is_req || is_set_range;

   // Work out the frame span of the command
   always_comb begin
      end_sum     = (CW+1)'(first_ff) + (CW+1)'(count_ff);
      end_ex      = (end_sum > lim_x) ? lim_x : end_sum;
      span_skip   = 1'b1;
      span_lo     = first_ff;
      span_hi     = FW'(end_ex - (CW+1)'(1));
      span_status = pfba_pkg::ST_DONE;
      if (is_req) begin
         span_skip   = (ss_ff >= lim);
         span_lo     = ss_ff[FW-1:0];
         span_hi     = FW'(lim - CW'(1));
         span_status = span_skip ? pfba_pkg::ST_NO_MEM : pfba_pkg::ST_DONE;
      end else if (is_clr_op || is_set_range) begin
         span_skip   = (end_ex <= (CW+1)'(first_ff));
         span_status = ((count_ff != '0) && (end_sum > lim_x)) ? pfba_pkg::ST_BEYOND
                                                                : pfba_pkg::ST_DONE;
      end
   end

   // Word evaluation
   assign last    = (word_ff == hi_ff[FW-1:OW]);
   assign lo_mask = (word_ff == lo_ff[FW-1:OW]) ? ({WB{1'b1}} << lo_ff[OW-1:0]) : '1;
   assign hi_mask = last ? ({WB{1'b1}} >> (OW'(WB-1) - hi_ff[OW-1:0])) : '1;
   assign mask    = lo_mask & hi_mask;
   assign chg     = set_like ? (~rd_ff & mask) : (rd_ff & mask);
   assign pos     = pfba_pkg::low_pos(chg);

   always_comb begin
      if (is_req) begin
         new_word = (|chg) ? (rd_ff | (WB'(1) << pos)) : rd_ff;
         pop      = PW'(|chg);
      end else begin
         new_word = is_set_range ? (rd_ff | mask) : (rd_ff & ~mask);
         pop      = pfba_pkg::pop32(chg);
      end
   end

   assign cur_idx = {word_ff, pos_ff};

   assign we    = cmd.clr || cmd.eval;
   assign waddr = cmd.clr ? clr_ff : word_ff[AW-1:0];
   assign wdata = cmd.clr ? '0 : new_word;

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      if (cmd.rd) rd_ff <= mem[word_ff[AW-1:0]];
   end

   // Command payload and span
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= in_opcode;
         first_ff <= in_frame_number;
         count_ff <= in_frame_count;
      end
      if (cmd.span) begin
         lo_ff      <= span_lo;
         hi_ff      <= span_hi;
         skip_ff    <= span_skip;
         status_ff  <= span_status;
         word_ff    <= span_lo[FW-1:OW];
         granted_ff <= '0;
      end
      if (cmd.eval) begin
         chg_any_ff <= |chg;
         pos_ff     <= pos;
         pop_ff     <= pop;
      end
      if (cmd.acc) begin
         if (is_req && chg_any_ff) granted_ff <= cur_idx;
         if (is_req && !chg_any_ff && last) status_ff <= pfba_pkg::ST_NO_MEM;
         if (!stat.finish) word_ff <= word_ff + IW'(1);
      end
   end

   // Allocator state
   always_ff @(posedge clock) begin
      if (reset) begin
         ss_ff   <= '0;
         used_ff <= '0;
         rsv_ff  <= '0;
         clr_ff  <= '0;
      end else begin
         if (cmd.clr) clr_ff <= clr_ff + AW'(1);
         if (cmd.acc) begin
            if (is_req) begin
               if (chg_any_ff) begin
                  used_ff <= sat_add(used_ff, PW'(1));
                  ss_ff   <= CW'(cur_idx);
               end else if (last) begin
                  ss_ff <= lim;
               end
            end else begin
               case (op_ff)
                  pfba_pkg::OP_FREE:      used_ff <= sat_sub(used_ff, pop_ff);
                  pfba_pkg::OP_UNRESERVE: rsv_ff  <= sat_sub(rsv_ff, pop_ff);
                  pfba_pkg::OP_LOCK:      used_ff <= sat_add(used_ff, pop_ff);
                  pfba_pkg::OP_RESERVE:   rsv_ff  <= sat_add(rsv_ff, pop_ff);
                  default:                used_ff <= used_ff;
               endcase
               if (is_clr_op && chg_any_ff && (CW'(cur_idx) < ss_ff)) ss_ff <= CW'(cur_idx);
            end
         end
      end
   end

   assign stat.clear_last = (clr_ff == AW'(pfba_pkg::MEM_WORDS - 1));
   assign stat.skip       = skip_ff;
   assign stat.finish     = is_req ? (chg_any_ff || last) : last;

   assign total           = {1'b0, used_ff} + {1'b0, rsv_ff};
   assign free_frames     = (lim_x > total) ? CW'(lim_x - total) : '0;
   assign granted_frame   = granted_ff;
   assign status          = status_ff;
   assign used_frames     = used_ff;
   assign reserved_frames = rsv_ff;

endmodule

>>> design/page_frame_bitmap_allocator_unit.sv
// Channel   Dir  Ports            Contents
// req       in   req_t*           command: opcode in tuser, frame number and count in tdata
// rsp       out  rsp_t*           one reply per command: grant, status and counters
// csr       in   csr_p*           frame_limit register at byte address 0
//
// A command takes setup and reply steps plus, for each 32-frame bitmap word it visits,
// a read, an evaluate-and-write-back and an account step. A command with nothing to touch
// (zero count, span at or past the limit, unknown opcode, empty search) still spends
// one read slot. The bitmap memory has a single write port and the sequencer works
// one word at a time; a request stops at the first word holding a clear frame, a range
// command walks every word of its span. After reset a clearing pass zeroes the bitmap,
// one word a cycle, during which req_tready stays low. A reply waits in the output
// register while rsp_tready is low; the next command is still taken and runs up to its
// own reply.
module page_frame_bitmap_allocator_unit (
   input  logic                           clock,
   input  logic                           reset,
   // opcode
   input  logic [2:0]                     req_tuser,
   // frame_number [15:0], frame_count [32:16], zero fill [39:33]
   input  logic [39:0]                    req_tdata,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // granted_frame [15:0], status [17:16], free_frames [34:18],
   // used_frames [51:35], reserved_frames [68:52], zero fill [71:69]
   output logic [71:0]                    rsp_tdata,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [pfba_pkg::CSR_AW-1:0]    csr_paddr,
   input  logic [31:0]                    csr_pwdata,
   output logic [31:0]                    csr_prdata,
   output logic                           csr_pready
);

   localparam int FW = pfba_pkg::FRAME_W;
   localparam int CW = pfba_pkg::CNT_W;

   pfba_pkg::ctrl_cmd_type cmd;
   pfba_pkg::dp_stat_type  stat;
   pfba_pkg::state_type    state;

   logic [CW-1:0] frame_limit_ff;
   logic          rsp_valid_ff;
   logic [71:0]   rsp_data_ff;
   logic          out_free;
   logic          csr_wr;
   logic          req_xfer;

   logic [FW-1:0] granted_frame;
   logic [1:0]    status;
   logic [CW-1:0] free_frames, used_frames, reserved_frames;

   // Register port: writes land on the access cycle, reads are immediate
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == pfba_pkg::REG_FRAME_LIMIT_IDX) ? 32'(frame_limit_ff)
                                                                         : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_limit_ff <= pfba_pkg::LIMIT_RESET;
      end else if (csr_wr && (csr_paddr[2] == pfba_pkg::REG_FRAME_LIMIT_IDX)) begin
         frame_limit_ff <= csr_pwdata[CW-1:0];
      end
   end

   // The output register frees up when empty or when its transfer completes now
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = cmd.ready;
   assign req_xfer   = req_tvalid && req_tready;

   pfba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .out_free  (out_free),
      .stat      (stat),
      .cmd       (cmd),
      .state     (state)
   );

   pfba_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .in_opcode       (req_tuser),
      .in_frame_number (req_tdata[15:0]),
      .in_frame_count  (req_tdata[32:16]),
      .frame_limit     (frame_limit_ff),
      .stat            (stat),
      .granted_frame   (granted_frame),
      .status          (status),
      .free_frames     (free_frames),
      .used_frames     (used_frames),
      .reserved_frames (reserved_frames)
   );

   // Hold the reply until its transfer; load a new one on emit
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_data_ff <= {3'b000, reserved_frames, used_frames, free_frames, status,
                         granted_frame};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // One command in flight: the cycle after a transfer no new command is taken
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> !req_tready)
      else $error("command taken while another is in flight");

   // A reply never overwrites one still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || rsp_tready))
      else $error("reply overwritten before transfer");

   // No command is taken during the clearing pass
   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      (state == pfba_pkg::S_CLEAR) |-> !req_tready)
      else $error("command accepted during bitmap clear");

   // Status code is always one of done, out of memory, beyond limit
   a_status_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff[17:16] != 2'd3))
      else $error("illegal status code in reply");

endmodule
